// ===== hw/rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Word type, controller states, initial hash values, round constants and the
// SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PAD      = 7'b0000010,
        ST_LOAD     = 7'b0000100,
        ST_ROUND    = 7'b0001000,
        ST_FIN      = 7'b0010000,
        ST_OUT_RD   = 7'b0100000,
        ST_OUT_SEND = 7'b1000000
    } t_state;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned HASH_WORDS = 8;

    function automatic t_word iv_const(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic t_word k_const(input logic [5:0] idx);
        t_word v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered with a read enable.
// ----------------------------------------------------------------------------
module sha256_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight 32-bit digest words.
//
// The slave channel takes one message byte per request: tdata carries the
// byte, tuser says whether the byte belongs to the message, and tlast closes
// the message (a request with tuser low and tlast high ends it without a
// byte, so an empty message is allowed). The byte that fills a 64-byte block
// starts a compression (loading the block and chaining RAMs, 64 rounds,
// updating the chaining RAM), during which tready is low. After tlast the
// padding is written one word per cycle, one or two further compressions
// follow, and the digest is sent on the master channel, words 0 to 7, each
// read from the chaining RAM and then offered; tlast marks word 7.
// A stalled receiver simply holds the current word. No new request is taken
// until word 7 has gone, after which a new message starts. Reset returns the
// block to the initial hash value with an empty byte count; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] has_byte
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_tlast    // last_word
);

    sha256_pkg::t_state r_state, n_state;
    logic [6:0]         r_cnt, n_cnt;
    logic [3:0]         r_wi, n_wi;
    logic               r_first, n_first;
    logic               r_lenblk, n_lenblk;
    logic               r_go_pad, n_go_pad;
    logic               r_go_out, n_go_out;
    logic               r_cv_fresh, n_cv_fresh;
    logic [60:0]        r_count, n_count;
    logic [31:0]        r_acc, n_acc;

    sha256_pkg::t_word r_w  [sha256_pkg::BLK_WORDS];
    sha256_pkg::t_word r_wv [sha256_pkg::HASH_WORDS];

    logic                blk_we, blk_re, cv_we, cv_re;
    logic [3:0]          blk_waddr, blk_raddr;
    logic [2:0]          cv_waddr, cv_raddr;
    sha256_pkg::t_word   blk_wdata, blk_q, cv_wdata, cv_q;

    logic                s_accept;
    logic [5:0]          pos, pos_next;
    logic [1:0]          boff;
    logic [2:0]          lag_idx;
    sha256_pkg::t_word   acc_byte, pad_word, pad_mask, cv_word;
    sha256_pkg::t_word   t1, t2, w_new;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign pos      = r_count[5:0];
    assign boff     = pos[1:0];
    assign pos_next = i_s_tuser ? pos + 6'd1 : pos;
    assign lag_idx  = 3'(r_cnt - 7'd1);

    assign acc_byte = ((boff == 2'd0) ? 32'd0 : r_acc)
                    | (32'(i_s_tdata) << {~boff, 3'b000});
    assign pad_mask = (boff == 2'd0) ? 32'd0 : ~(32'hFFFF_FFFF >> {boff, 3'b000});
    assign pad_word = (r_acc & pad_mask) | (32'(sha256_pkg::PAD_BYTE) << {~boff, 3'b000});

    assign cv_word = r_cv_fresh ? sha256_pkg::iv_const(lag_idx) : cv_q;

    assign t1 = r_wv[7] + sha256_pkg::big_sigma1(r_wv[4])
              + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
              + sha256_pkg::k_const(r_cnt[5:0]) + r_w[0];
    assign t2 = sha256_pkg::big_sigma0(r_wv[0])
              + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
    assign w_new = r_w[0] + sha256_pkg::small_sigma0(r_w[1]) + r_w[9]
                 + sha256_pkg::small_sigma1(r_w[14]);

    assign o_s_tready = (r_state == sha256_pkg::ST_IDLE);
    assign o_m_tvalid = (r_state == sha256_pkg::ST_OUT_SEND);
    assign o_m_tdata  = {5'd0, r_cnt[2:0], cv_q};
    assign o_m_tlast  = (r_cnt[2:0] == 3'd7);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_wi       = r_wi;
        n_first    = r_first;
        n_lenblk   = r_lenblk;
        n_go_pad   = r_go_pad;
        n_go_out   = r_go_out;
        n_cv_fresh = r_cv_fresh;
        n_count    = r_count;
        n_acc      = r_acc;
        blk_we     = 1'b0;
        blk_waddr  = pos[5:2];
        blk_wdata  = acc_byte;
        blk_re     = 1'b0;
        blk_raddr  = r_cnt[3:0];
        cv_we      = 1'b0;
        cv_waddr   = lag_idx;
        cv_wdata   = cv_word + r_wv[lag_idx];
        cv_re      = 1'b0;
        cv_raddr   = r_cnt[2:0];
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser) begin
                        n_count = r_count + 61'd1;
                        n_acc   = acc_byte;
                        blk_we  = (boff == 2'd3);
                    end
                    if (i_s_tuser && pos == 6'd63) begin
                        n_state  = sha256_pkg::ST_LOAD;
                        n_cnt    = 7'd0;
                        n_go_pad = i_s_tlast;
                        n_go_out = 1'b0;
                        n_wi     = 4'd0;
                        n_first  = 1'b1;
                        n_lenblk = 1'b1;
                    end else if (i_s_tlast) begin
                        n_state  = sha256_pkg::ST_PAD;
                        n_wi     = pos_next[5:2];
                        n_first  = 1'b1;
                        n_lenblk = !(&pos_next[5:3]);
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                blk_we    = 1'b1;
                blk_waddr = r_wi;
                if (r_first) begin
                    blk_wdata = pad_word;
                end else if (r_lenblk && r_wi == 4'd14) begin
                    blk_wdata = r_count[60:29];
                end else if (r_lenblk && r_wi == 4'd15) begin
                    blk_wdata = {r_count[28:0], 3'b000};
                end else begin
                    blk_wdata = 32'd0;
                end
                n_first = 1'b0;
                if (r_wi == 4'd15) begin
                    n_state  = sha256_pkg::ST_LOAD;
                    n_cnt    = 7'd0;
                    n_go_out = r_lenblk;
                    n_go_pad = !r_lenblk;
                    n_wi     = 4'd0;
                    n_lenblk = 1'b1;
                end else begin
                    n_wi = r_wi + 4'd1;
                end
            end
            sha256_pkg::ST_LOAD: begin
                blk_re = (r_cnt < 7'(sha256_pkg::BLK_WORDS));
                cv_re  = (r_cnt < 7'(sha256_pkg::HASH_WORDS));
                if (r_cnt == 7'(sha256_pkg::BLK_WORDS)) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_cnt == 7'(sha256_pkg::NUM_ROUNDS - 1)) begin
                    n_state = sha256_pkg::ST_FIN;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha256_pkg::ST_FIN: begin
                cv_re = (r_cnt < 7'(sha256_pkg::HASH_WORDS));
                cv_we = (r_cnt != 7'd0);
                if (r_cnt == 7'(sha256_pkg::HASH_WORDS)) begin
                    n_cv_fresh = 1'b0;
                    n_cnt      = 7'd0;
                    priority if (r_go_out) begin
                        n_state = sha256_pkg::ST_OUT_RD;
                    end else if (r_go_pad) begin
                        n_state = sha256_pkg::ST_PAD;
                    end else begin
                        n_state = sha256_pkg::ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            sha256_pkg::ST_OUT_RD: begin
                cv_re   = 1'b1;
                n_state = sha256_pkg::ST_OUT_SEND;
            end
            sha256_pkg::ST_OUT_SEND: begin
                if (i_m_tready) begin
                    if (r_cnt[2:0] == 3'd7) begin
                        n_state    = sha256_pkg::ST_IDLE;
                        n_count    = 61'd0;
                        n_cv_fresh = 1'b1;
                        n_cnt      = 7'd0;
                    end else begin
                        n_state = sha256_pkg::ST_OUT_RD;
                        n_cnt   = r_cnt + 7'd1;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_IDLE;
            r_cnt      <= 7'd0;
            r_wi       <= 4'd0;
            r_first    <= 1'b0;
            r_lenblk   <= 1'b0;
            r_go_pad   <= 1'b0;
            r_go_out   <= 1'b0;
            r_cv_fresh <= 1'b1;
            r_count    <= 61'd0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_wi       <= n_wi;
            r_first    <= n_first;
            r_lenblk   <= n_lenblk;
            r_go_pad   <= n_go_pad;
            r_go_out   <= n_go_out;
            r_cv_fresh <= n_cv_fresh;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_state == sha256_pkg::ST_LOAD && r_cnt != 7'd0) begin
            for (int i = 0; i < sha256_pkg::BLK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha256_pkg::BLK_WORDS-1] <= blk_q;
            if (r_cnt <= 7'(sha256_pkg::HASH_WORDS)) begin
                r_wv[lag_idx] <= cv_word;
            end
        end else if (r_state == sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < sha256_pkg::BLK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha256_pkg::BLK_WORDS-1] <= w_new;
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
    end

    sha256_ram #(
        .WIDTH (32),
        .DEPTH (sha256_pkg::BLK_WORDS)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (blk_waddr),
        .i_wdata (blk_wdata),
        .i_re    (blk_re),
        .i_raddr (blk_raddr),
        .o_rdata (blk_q)
    );

    sha256_ram #(
        .WIDTH (32),
        .DEPTH (sha256_pkg::HASH_WORDS)
    ) u_cv_ram (
        .i_clk   (i_clk),
        .i_we    (cv_we),
        .i_waddr (cv_waddr),
        .i_wdata (cv_wdata),
        .i_re    (cv_re),
        .i_raddr (cv_raddr),
        .o_rdata (cv_q)
    );

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("Input accepted while a digest word is pending.");

    a_cv_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cv_we && cv_re) |-> (cv_waddr != cv_raddr))
        else $error("Chaining RAM read and write hit the same entry.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (r_cv_fresh && r_count == 61'd0))
        else $error("Message state not restarted after the digest.");

    a_pad_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("Request taken before the digest of the previous message.");

endmodule

// ===== verif/sha256_stream_hasher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds messages one byte per request, including empty messages, requests
// that carry no byte, and lengths around the padding and block boundaries.
// A scoreboard keeps its own SHA-256 state, works out the eight digest words
// of every closed message and checks each word that the block returns, under
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;

    typedef struct packed {
        sha256_pkg::t_word word;
        logic [2:0]        index;
        logic              last;
    } t_digest_entry;

    localparam sha256_pkg::t_word START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam sha256_pkg::t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    class digest_checker;
        sha256_pkg::t_word chain [8];
        logic [7:0]        block_bytes [64];
        logic [60:0]       byte_total;
        t_digest_entry     digest_words_due [$];
        int                errors;

        function new();
            errors = 0;
            foreach (block_bytes[i]) block_bytes[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = START_HASH[i];
            byte_total = '0;
        endfunction

        function sha256_pkg::t_word ror32(input sha256_pkg::t_word x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            sha256_pkg::t_word sched [64];
            sha256_pkg::t_word v [8];
            sha256_pkg::t_word s0;
            sha256_pkg::t_word s1;
            sha256_pkg::t_word t1;
            sha256_pkg::t_word t2;
            int                i;
            for (i = 0; i < 16; i++) begin
                sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                            block_bytes[4*i+2], block_bytes[4*i+3]};
            end
            for (i = 16; i < 64; i++) begin
                s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            for (i = 0; i < 8; i++) v[i] = chain[i];
            for (i = 0; i < 64; i++) begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void take_request(input logic [7:0] data, input logic has,
                                   input logic last);
            logic [63:0]   bit_length;
            t_digest_entry entry;
            int            pos;
            int            i;
            if (has) begin
                pos = byte_total[5:0];
                block_bytes[pos] = data;
                byte_total = byte_total + 1'b1;
                if (pos == 63) compress_block();
            end
            if (!last) return;
            pos = byte_total[5:0];
            block_bytes[pos] = sha256_pkg::PAD_BYTE;
            for (i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
            // No room for the length after the pad byte: close this block first.
            if (pos >= 56) begin
                compress_block();
                for (i = 0; i < 56; i++) block_bytes[i] = 8'h00;
            end
            bit_length = {byte_total, 3'b000};
            for (i = 0; i < 8; i++) block_bytes[56+i] = bit_length[63-8*i -: 8];
            compress_block();
            for (i = 0; i < 8; i++) begin
                entry.word  = chain[i];
                entry.index = 3'(i);
                entry.last  = (i == 7);
                digest_words_due.push_back(entry);
            end
            restart();
        endfunction

        function void check_word(input logic [39:0] tdata, input logic tlast);
            t_digest_entry due;
            if (digest_words_due.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, got %010h last %0b",
                         $time, tdata, tlast);
                errors++;
                return;
            end
            due = digest_words_due.pop_front();
            if (tdata[31:0] !== due.word) begin
                $display("%0t: digest word %0d: expected %08h, got %08h",
                         $time, due.index, due.word, tdata[31:0]);
                errors++;
            end
            if (tdata[34:32] !== due.index) begin
                $display("%0t: word index: expected %0d, got %0d",
                         $time, due.index, tdata[34:32]);
                errors++;
            end
            if (tlast !== due.last) begin
                $display("%0t: last word flag of word %0d: expected %0b, got %0b",
                         $time, due.index, due.last, tlast);
                errors++;
            end
        endfunction

        function int pending();
            return digest_words_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_last;

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            phase_items;
    digest_checker board;

    sha256_stream_hasher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),   // [7:0] data_byte
        .i_s_tuser  (s_user),   // [0] has_byte
        .i_s_tlast  (s_last),   // is_last
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),   // [31:0] digest_word, [34:32] word_index
        .o_m_tlast  (m_last)    // last_word
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            board.check_word(m_data, m_last);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(input logic [7:0] data, input logic has,
                                input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= has;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        board.take_request(data, has, last);
        phase_items++;
    endtask

    task automatic send_message(input int len, input bit byte_on_last);
        logic closes;
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(11) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            closes = byte_on_last && (n == len - 1);
            send_request(8'($urandom_range(255)), 1'b1, closes);
        end
        if (!(byte_on_last && len > 0)) begin
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
        int len;
        int pick;
        int boundary [6];
        boundary = '{55, 56, 57, 62, 63, 64};
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_items = 0;
        while (phase_items < budget) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                len = $urandom_range(9);
            end else if (pick < 8) begin
                len = boundary[$urandom_range(5)];
            end else begin
                len = $urandom_range(40, 10);
            end
            send_message(len, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        #5_000_000;
        $display("sha256_stream_hasher_test failed");
        $finish;
    end

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 61;
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h7F, 1'b1, 1'b0);
        send_request(8'hAA, 1'b1, 1'b0);
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);

        run_phase(20, 61, 55);
        run_phase(61, 20, 55);
        run_phase(0, 0, 55);

        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("sha256_stream_hasher_test passed");
        end else begin
            $display("sha256_stream_hasher_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ram.sv
hw/rtl/sha256_stream_hasher.sv
verif/sha256_stream_hasher_test.sv
